@@ rtl/lsd_pkg.sv @@
// Shared types and constants for the LZSS stream decompressor.
// Used by lsd_window, lsd_seq and the top level; depends on nothing.
package lsd_pkg;

    // window geometry and match limits of the stream format
    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int MAX_MATCH       = 18;
    localparam int MIN_MATCH       = 3;
    localparam int COUNT_W         = $clog2(MAX_MATCH + 1);

    // byte the window holds after reset
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DATA
    } state_t;

    // meaning of the next compressed byte
    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_BIT    = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

endpackage

@@ rtl/lsd_window.sv @@
// History window of the decompressor: one write port, one registered read port.
// Depends on lsd_pkg for the default window size.
module lsd_window #(
    parameter int WINDOW_SIZE = lsd_pkg::WINDOW_SIZE_DEF,
    localparam int AW = $clog2(WINDOW_SIZE)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [WINDOW_SIZE];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lsd_seq.sv @@
// Decode sequencer: flag tracking, match copy loop, shared address incrementer
// and output register. Depends on lsd_pkg; drives the ports of lsd_window.
module lsd_seq #(
    parameter int WINDOW_SIZE = lsd_pkg::WINDOW_SIZE_DEF,
    localparam int AW = $clog2(WINDOW_SIZE)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          last_of_run,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam int CW = lsd_pkg::COUNT_W;
    localparam logic [AW-1:0] WP_RESET = AW'(WINDOW_SIZE - lsd_pkg::MAX_MATCH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_SIZE - 1);

    lsd_pkg::state_t state_reg, state_next;
    lsd_pkg::phase_t phase_reg, phase_next;

    logic [7:0]    flag_bits_reg, flag_bits_next;
    logic [2:0]    flag_index_reg, flag_index_next;
    logic [7:0]    offset_low_reg, offset_low_next;
    logic [AW-1:0] write_pos_reg, write_pos_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          last_reg, last_next;

    // shared address incrementer, wraps at the window size
    logic [AW-1:0] inc_in;
    logic [AW-1:0] inc_out;
    logic          out_free;
    logic          in_take;

    assign inc_out  = inc_in + AW'(1);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == lsd_pkg::ST_IDLE) && out_free;
    assign in_take  = in_valid && in_ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lsd_pkg::ST_CLEAR;
            phase_reg      <= lsd_pkg::PH_FLAG;
            flag_bits_reg  <= '0;
            flag_index_reg <= '0;
            offset_low_reg <= '0;
            write_pos_reg  <= WP_RESET;
            ptr_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flag_index_reg <= flag_index_next;
            offset_low_reg <= offset_low_next;
            write_pos_reg  <= write_pos_next;
            ptr_reg        <= ptr_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    // next state, memory control and output loading
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        flag_bits_next  = flag_bits_reg;
        flag_index_next = flag_index_reg;
        offset_low_next = offset_low_reg;
        write_pos_next  = write_pos_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        inc_in          = write_pos_reg;
        mem_we          = 1'b0;
        mem_waddr       = write_pos_reg;
        mem_wdata       = in_byte;
        mem_re          = 1'b0;
        mem_raddr       = ptr_reg;

        case (state_reg)
            lsd_pkg::ST_CLEAR:
            begin
                // sweep the window with spaces, ptr walks every address
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = lsd_pkg::SPACE_CHAR;
                inc_in    = ptr_reg;
                ptr_next  = inc_out;
                if (ptr_reg == ADDR_LAST)
                begin
                    state_next = lsd_pkg::ST_IDLE;
                end
            end

            lsd_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    case (phase_reg)
                        lsd_pkg::PH_BIT:
                        begin
                            if (flag_bits_reg[0])
                            begin
                                // literal: store, emit, advance flag
                                mem_we          = 1'b1;
                                inc_in          = write_pos_reg;
                                write_pos_next  = inc_out;
                                out_valid_next  = 1'b1;
                                out_byte_next   = in_byte;
                                last_next       = 1'b1;
                                flag_bits_next  = flag_bits_reg >> 1;
                                flag_index_next = flag_index_reg + 3'd1;
                                phase_next      = (flag_index_reg == 3'd7) ?
                                                  lsd_pkg::PH_FLAG : lsd_pkg::PH_BIT;
                            end
                            else
                            begin
                                // hold first match byte
                                offset_low_next = in_byte;
                                phase_next      = lsd_pkg::PH_SECOND;
                            end
                        end

                        lsd_pkg::PH_SECOND:
                        begin
                            // start the copy loop
                            ptr_next   = AW'({in_byte[7:4], offset_low_reg});
                            count_next = CW'(in_byte[3:0]) + CW'(lsd_pkg::MIN_MATCH);
                            state_next = lsd_pkg::ST_READ;
                        end

                        default:
                        begin
                            // flag byte, also taken for the unused phase code
                            flag_bits_next  = in_byte;
                            flag_index_next = '0;
                            phase_next      = lsd_pkg::PH_BIT;
                        end
                    endcase
                end
            end

            lsd_pkg::ST_READ:
            begin
                // fetch the next match byte and advance the source pointer
                mem_re     = 1'b1;
                inc_in     = ptr_reg;
                ptr_next   = inc_out;
                state_next = lsd_pkg::ST_DATA;
            end

            lsd_pkg::ST_DATA:
            begin
                // write back and emit once the output register is free
                if (out_free)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = mem_rdata;
                    inc_in         = write_pos_reg;
                    write_pos_next = inc_out;
                    out_valid_next = 1'b1;
                    out_byte_next  = mem_rdata;
                    last_next      = (count_reg == CW'(1));
                    count_next     = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        flag_bits_next  = flag_bits_reg >> 1;
                        flag_index_next = flag_index_reg + 3'd1;
                        phase_next      = (flag_index_reg == 3'd7) ?
                                          lsd_pkg::PH_FLAG : lsd_pkg::PH_BIT;
                        state_next      = lsd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lsd_pkg::ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = lsd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

@@ rtl/lzss_stream_decompressor.sv @@
// Top level of the LZSS stream decompressor (4096-byte window, flag bits LSB first).
// Depends on lsd_pkg, lsd_window and lsd_seq.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   in_byte
//  out      source     out_valid / out_ready out_byte, last_of_run
//
// Flag bytes, first match bytes and literals are taken in ST_IDLE without leaving it.
// The second match byte starts a copy loop: ST_READ reads each byte, ST_DATA writes
// and emits it, set by the read-then-write turn through the window memory.
// After reset the window is swept to spaces over all WINDOW_SIZE (4096) addresses with
// in_ready low. A stalled output holds the sequencer; in_ready is low during a copy.
module lzss_stream_decompressor #(
    parameter int WINDOW_SIZE = lsd_pkg::WINDOW_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    localparam int AW = $clog2(WINDOW_SIZE);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // decode sequencer
    lsd_seq #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // history window
    lsd_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

@@ rtl/lsd_checker.sv @@
// Port-level checks for the LZSS stream decompressor, bound to the top level.
// Depends only on the top-level ports.
module lsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run
);

    // a waiting input word holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte))
        else $error("waiting input word changed");

    // a stalled output word holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("stalled output word changed");

    // no input is taken while a run is still being delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("input taken in the middle of a run");

    // input is taken only when the output register can accept a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("input ready while output is blocked");

    // leaving reset starts the window sweep with both channels quiet
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready && !out_valid)
        else $error("activity right after reset");

endmodule

bind lzss_stream_decompressor lsd_checker u_lsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);
